>>> sv/projectile_plane_impact_unit_defines.svh
// Assertion macros shared by the projectile plane impact RTL.
`ifndef PROJECTILE_PLANE_IMPACT_UNIT_DEFINES_SVH
`define PROJECTILE_PLANE_IMPACT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PPI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppi: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define PPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppi: next-cycle check failed");

`endif

>>> sv/ppi_pkg.sv
// Package: constants, stage payload types and arithmetic helpers for the impact unit.
package ppi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_V_STEPS = 32;
  localparam int DIV_T_STEPS = 31;

  localparam logic signed [31:0] GRAVITY_RESET = -32'sd64225280;
  localparam logic signed [31:0] S32_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN       = 32'sh8000_0000;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [63:0] rem;
    logic        q;
  } div_st_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] h;
    logic signed [31:0] dh;
    logic [2:0][62:0]   pmag;
    logic [2:0]         psign;
  } ph_sqrt1_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] h;
    logic signed [31:0] dh;
    logic [2:0]         psign;
    logic [32:0]        len;
    logic               lenz;
    logic [2:0]         ovf;
  } ph_div1_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] h;
    logic signed [31:0] dh;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               has_root;
  } ph_geom_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] h;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               hit;
  } ph_time_t;

  function automatic logic [31:0] mag32(logic signed [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] x);
    if (x > 66'(S32_MAX)) return S32_MAX;
    if (x < 66'(S32_MIN)) return S32_MIN;
    return x[31:0];
  endfunction

  // One restoring square-root step at a fixed test bit.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [63:0] b);
    sqrt_st_t r;
    logic [63:0] trial;
    trial = s.root + b;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + b;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // One restoring division step against a pre-shifted divisor.
  function automatic div_st_t div_step(logic [63:0] rem, logic [63:0] dsh);
    div_st_t r;
    if (rem >= dsh) begin
      r.rem = rem - dsh;
      r.q   = 1'b1;
    end else begin
      r.rem = rem;
      r.q   = 1'b0;
    end
    return r;
  endfunction

  // Quotient num/den is non-negative; den is non-zero.
  function automatic logic time_nonneg(logic signed [34:0] num, logic signed [31:0] den);
    return (num == 35'sd0) || ((num > 35'sd0) == (den > 32'sd0));
  endfunction

endpackage

>>> sv/ppi_query_if.sv
// Interface: query channel carrying one launch description per transaction.
interface ppi_query_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] launch_speed;
  logic signed [31:0] plane_height;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           launch_speed, plane_height,
    input  ready
  );

  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           launch_speed, plane_height,
    output ready
  );
endinterface

>>> sv/ppi_impact_if.sv
// Interface: impact channel carrying the hit flag and impact point per transaction.
interface ppi_impact_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] impact_x;
  logic signed [31:0] impact_y;
  logic signed [31:0] impact_z;

  modport source (
    output valid, hit, impact_x, impact_y, impact_z,
    input  ready
  );

  modport sink (
    input  valid, hit, impact_x, impact_y, impact_z,
    output ready
  );
endinterface

>>> sv/projectile_plane_impact_unit.sv
// Top level: pipelined ballistic projectile versus horizontal plane intersection.
//
// Usage:
//   query  (sink)   one launch per transaction: origin, unnormalized direction,
//                   launch speed and plane height, all signed Q16.16.
//   impact (source) one result per query, in order: hit flag and impact point;
//                   the point reads zero when there is no hit.
//   cfg_wr_en / cfg_wr_data write the gravity acceleration (signed Q16.16);
//                   write it only while no query is in flight.
// One query is taken per cycle unless impact is stalled with a result waiting. The
// pipeline depth comes from two 32-step square-root pipelines (direction length,
// discriminant), a 32-step divider for the velocity lanes and a 31-step divider
// for the impact time.
// Reset (rst, synchronous) empties the pipeline and restores gravity to -980.0.
// When impact is stalled with a result waiting, the whole pipeline holds and
// query.ready drops; nothing is lost or repeated.
`include "projectile_plane_impact_unit_defines.svh"

module projectile_plane_impact_unit (
  input  logic        clk,
  input  logic        rst,
  ppi_query_if.sink   query,
  ppi_impact_if.source impact,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int SQ    = ppi_pkg::SQRT_STEPS;
  localparam int DV    = ppi_pkg::DIV_V_STEPS;
  localparam int DT    = ppi_pkg::DIV_T_STEPS;
  localparam int FB    = ppi_pkg::FRAC_BITS;
  localparam int DEPTH = 10 + 2 * SQ + DV + DT;

  // Control
  logic [DEPTH-1:0]   vld;
  logic               adv;
  logic               in_fire;
  logic signed [31:0] gravity;

  // Stage 1
  logic signed [31:0] dir [3];
  logic [31:0]        dmag [3];
  logic [63:0]        sqd [3];
  logic signed [63:0] prod [3];
  logic signed [31:0] dh_c;
  logic [63:0]        s1_sq [3];
  logic signed [63:0] s1_prod [3];
  logic signed [31:0] s1_ox, s1_oy, s1_h, s1_dh;

  // Length square root
  ppi_pkg::sqrt_st_t  sq1_st [SQ+1];
  ppi_pkg::sqrt_st_t  sq1_nx [SQ];
  ppi_pkg::ph_sqrt1_t sq1_pl [SQ+1];
  ppi_pkg::ph_sqrt1_t sq1_in;
  logic [32:0]        len_c;

  // Velocity division
  logic [2:0][63:0]   dv_rem [DV+1];
  logic [2:0][31:0]   dv_quo [DV+1];
  ppi_pkg::ph_div1_t  dv_pl  [DV+1];
  ppi_pkg::div_st_t   dv_nx  [DV][3];
  ppi_pkg::ph_div1_t  dv_in;

  // Velocity, products, discriminant root
  logic signed [31:0] vnew [3];
  ppi_pkg::ph_geom_t  vs_pl;
  ppi_pkg::ph_geom_t  pr_pl;
  logic [63:0]        pr_b2, pr_gd2;
  logic               pr_pos;
  ppi_pkg::sqrt_st_t  sq2_st [SQ+1];
  ppi_pkg::sqrt_st_t  sq2_nx [SQ];
  ppi_pkg::ph_geom_t  sq2_pl [SQ+1];
  ppi_pkg::ph_geom_t  sq2_in;
  logic [63:0]        disc_c;
  logic               has_root_c;

  // Root choice
  logic signed [34:0] num_c;
  logic signed [31:0] den_c;
  logic               hit_c;
  ppi_pkg::ph_time_t  ch_pl;
  logic [33:0]        ch_nmag;
  logic [31:0]        ch_dmag;

  // Time division
  logic [63:0]        dt_rem  [DT+1];
  logic [DT-1:0]      dt_quo  [DT+1];
  logic [31:0]        dt_dmag [DT+1];
  logic               dt_sat  [DT+1];
  ppi_pkg::ph_time_t  dt_pl   [DT+1];
  ppi_pkg::div_st_t   dt_nx   [DT];
  logic [63:0]        dt_num_c;

  // Impact products and output
  logic [DT-1:0]      t_c;
  ppi_pkg::ph_time_t  mu_pl;
  logic signed [63:0] mu_px, mu_py;
  logic signed [31:0] ix_c, iy_c;
  logic               out_hit;
  logic signed [31:0] out_x, out_y, out_z;

  // Advance everything unless a finished result is stalled
  assign adv         = !vld[DEPTH-1] || impact.ready;
  assign query.ready = adv;
  assign in_fire     = query.valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= ppi_pkg::GRAVITY_RESET;
    end else if (cfg_wr_en) begin
      gravity <= $signed(cfg_wr_data);
    end
  end

  // Squares of the direction, direction times speed, height difference
  always_comb begin
    dir[0] = query.dir_x;
    dir[1] = query.dir_y;
    dir[2] = query.dir_z;
    for (int i = 0; i < 3; i++) begin
      dmag[i] = ppi_pkg::mag32(dir[i]);
      sqd[i]  = dmag[i] * dmag[i];
      prod[i] = dir[i] * query.launch_speed;
    end
    dh_c = ppi_pkg::sat32(66'(query.plane_height) - 66'(query.origin_z));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq[i]   <= sqd[i];
        s1_prod[i] <= prod[i];
      end
      s1_ox <= query.origin_x;
      s1_oy <= query.origin_y;
      s1_h  <= query.plane_height;
      s1_dh <= dh_c;
    end
  end

  // Sum the squares and split the products into sign and magnitude
  always_comb begin
    sq1_in.ox = s1_ox;
    sq1_in.oy = s1_oy;
    sq1_in.h  = s1_h;
    sq1_in.dh = s1_dh;
    for (int i = 0; i < 3; i++) begin
      sq1_in.psign[i] = s1_prod[i][63];
      sq1_in.pmag[i]  = s1_prod[i][63] ? 63'(-s1_prod[i]) : s1_prod[i][62:0];
    end
    for (int k = 0; k < SQ; k++) begin
      sq1_nx[k] = ppi_pkg::sqrt_step(sq1_st[k], 64'd1 << (2 * (SQ - 1 - k)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq1_st[0].rem  <= s1_sq[0] + s1_sq[1] + s1_sq[2];
      sq1_st[0].root <= '0;
      sq1_pl[0]      <= sq1_in;
      for (int k = 0; k < SQ; k++) begin
        sq1_st[k+1] <= sq1_nx[k];
        sq1_pl[k+1] <= sq1_pl[k];
      end
    end
  end

  // Divide each product magnitude by the length, one quotient bit a stage
  assign len_c = sq1_st[SQ].root[32:0];

  always_comb begin
    dv_in.ox    = sq1_pl[SQ].ox;
    dv_in.oy    = sq1_pl[SQ].oy;
    dv_in.h     = sq1_pl[SQ].h;
    dv_in.dh    = sq1_pl[SQ].dh;
    dv_in.psign = sq1_pl[SQ].psign;
    dv_in.len   = len_c;
    dv_in.lenz  = (len_c == '0);
    for (int i = 0; i < 3; i++) begin
      dv_in.ovf[i] = {2'b00, sq1_pl[SQ].pmag[i]} >= {len_c, 32'd0};
    end
    for (int k = 0; k < DV; k++) begin
      for (int i = 0; i < 3; i++) begin
        dv_nx[k][i] = ppi_pkg::div_step(dv_rem[k][i], 64'(dv_pl[k].len) << (DV - 1 - k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {1'b0, sq1_pl[SQ].pmag[i]};
        dv_quo[0][i] <= '0;
      end
      dv_pl[0] <= dv_in;
      for (int k = 0; k < DV; k++) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[k+1][i] <= dv_nx[k][i].rem;
          dv_quo[k+1][i] <= {dv_quo[k][i][30:0], dv_nx[k][i].q};
        end
        dv_pl[k+1] <= dv_pl[k];
      end
    end
  end

  // Saturate the signed velocity lanes; zero direction gives zero velocity
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_pl[DV].lenz) begin
        vnew[i] = '0;
      end else if (dv_pl[DV].psign[i]) begin
        vnew[i] = (dv_pl[DV].ovf[i] || dv_quo[DV][i] > 32'h8000_0000) ?
                  ppi_pkg::S32_MIN : $signed(~dv_quo[DV][i] + 32'd1);
      end else begin
        vnew[i] = (dv_pl[DV].ovf[i] || dv_quo[DV][i][31]) ?
                  ppi_pkg::S32_MAX : $signed(dv_quo[DV][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vs_pl.ox       <= dv_pl[DV].ox;
      vs_pl.oy       <= dv_pl[DV].oy;
      vs_pl.h        <= dv_pl[DV].h;
      vs_pl.dh       <= dv_pl[DV].dh;
      vs_pl.vx       <= vnew[0];
      vs_pl.vy       <= vnew[1];
      vs_pl.vz       <= vnew[2];
      vs_pl.has_root <= 1'b0;
    end
  end

  // Discriminant terms: vz squared and twice gravity times height difference
  always_ff @(posedge clk) begin
    if (adv) begin
      pr_pl  <= vs_pl;
      pr_b2  <= ppi_pkg::mag32(vs_pl.vz) * ppi_pkg::mag32(vs_pl.vz);
      pr_gd2 <= (ppi_pkg::mag32(gravity) * ppi_pkg::mag32(vs_pl.dh)) << 1;
      pr_pos <= ((gravity < 32'sd0) == (vs_pl.dh < 32'sd0)) || (vs_pl.dh == 32'sd0);
    end
  end

  // Form the discriminant, then take its square root
  always_comb begin
    has_root_c = 1'b1;
    if (pr_pos) begin
      disc_c = pr_b2 + pr_gd2;
    end else if (pr_b2 >= pr_gd2) begin
      disc_c = pr_b2 - pr_gd2;
    end else begin
      disc_c     = '0;
      has_root_c = 1'b0;
    end
    sq2_in          = pr_pl;
    sq2_in.has_root = has_root_c;
    for (int k = 0; k < SQ; k++) begin
      sq2_nx[k] = ppi_pkg::sqrt_step(sq2_st[k], 64'd1 << (2 * (SQ - 1 - k)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq2_st[0].rem  <= disc_c;
      sq2_st[0].root <= '0;
      sq2_pl[0]      <= sq2_in;
      for (int k = 0; k < SQ; k++) begin
        sq2_st[k+1] <= sq2_nx[k];
        sq2_pl[k+1] <= sq2_pl[k];
      end
    end
  end

  // Pick the earliest non-negative time: linear or quadratic solve
  always_comb begin
    logic signed [34:0] nvz, nm, np, first, second;
    nvz    = -35'(sq2_pl[SQ].vz);
    nm     = nvz - $signed({2'b00, sq2_st[SQ].root[32:0]});
    np     = nvz + $signed({2'b00, sq2_st[SQ].root[32:0]});
    first  = (gravity > 32'sd0) ? nm : np;
    second = (gravity > 32'sd0) ? np : nm;
    num_c  = '0;
    den_c  = gravity;
    hit_c  = 1'b0;
    if (gravity == 32'sd0) begin
      num_c = 35'(sq2_pl[SQ].dh);
      den_c = sq2_pl[SQ].vz;
      hit_c = (sq2_pl[SQ].vz != 32'sd0) &&
              ppi_pkg::time_nonneg(35'(sq2_pl[SQ].dh), sq2_pl[SQ].vz);
    end else if (sq2_pl[SQ].has_root) begin
      if (ppi_pkg::time_nonneg(first, gravity)) begin
        num_c = first;
        hit_c = 1'b1;
      end else if (ppi_pkg::time_nonneg(second, gravity)) begin
        num_c = second;
        hit_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch_pl.ox  <= sq2_pl[SQ].ox;
      ch_pl.oy  <= sq2_pl[SQ].oy;
      ch_pl.h   <= sq2_pl[SQ].h;
      ch_pl.vx  <= sq2_pl[SQ].vx;
      ch_pl.vy  <= sq2_pl[SQ].vy;
      ch_pl.hit <= hit_c;
      ch_nmag   <= num_c[34] ? 34'(-num_c) : num_c[33:0];
      ch_dmag   <= ppi_pkg::mag32(den_c);
    end
  end

  // Divide the time magnitude, saturating at the largest positive value
  assign dt_num_c = {30'd0, ch_nmag} << FB;

  always_comb begin
    for (int k = 0; k < DT; k++) begin
      dt_nx[k] = ppi_pkg::div_step(dt_rem[k], 64'(dt_dmag[k]) << (DT - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dt_rem[0]  <= dt_num_c;
      dt_quo[0]  <= '0;
      dt_dmag[0] <= ch_dmag;
      dt_sat[0]  <= dt_num_c >= ({32'd0, ch_dmag} << DT);
      dt_pl[0]   <= ch_pl;
      for (int k = 0; k < DT; k++) begin
        dt_rem[k+1]  <= dt_nx[k].rem;
        dt_quo[k+1]  <= {dt_quo[k][DT-2:0], dt_nx[k].q};
        dt_dmag[k+1] <= dt_dmag[k];
        dt_sat[k+1]  <= dt_sat[k];
        dt_pl[k+1]   <= dt_pl[k];
      end
    end
  end

  // Velocity times time
  assign t_c = dt_sat[DT] ? '1 : dt_quo[DT];

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_pl <= dt_pl[DT];
      mu_px <= dt_pl[DT].vx * $signed({1'b0, t_c});
      mu_py <= dt_pl[DT].vy * $signed({1'b0, t_c});
    end
  end

  // Scale back, add the origin, saturate; drop the point on a miss
  always_comb begin
    logic [63:0] mx, my;
    mx   = (mu_px[63] ? (~mu_px + 64'd1) : mu_px) >> FB;
    my   = (mu_py[63] ? (~mu_py + 64'd1) : mu_py) >> FB;
    ix_c = ppi_pkg::sat32(66'(mu_pl.ox) +
           (mu_px[63] ? -$signed({2'b00, mx}) : $signed({2'b00, mx})));
    iy_c = ppi_pkg::sat32(66'(mu_pl.oy) +
           (mu_py[63] ? -$signed({2'b00, my}) : $signed({2'b00, my})));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit <= mu_pl.hit;
      out_x   <= mu_pl.hit ? ix_c : '0;
      out_y   <= mu_pl.hit ? iy_c : '0;
      out_z   <= mu_pl.hit ? mu_pl.h : '0;
    end
  end

  assign impact.valid    = vld[DEPTH-1];
  assign impact.hit      = out_hit;
  assign impact.impact_x = out_x;
  assign impact.impact_y = out_y;
  assign impact.impact_z = out_z;

  // Checks
  `PPI_ASSERT_IMPL(a_miss_zero, impact.valid && !out_hit, {out_x, out_y, out_z} == 96'd0)
  `PPI_ASSERT_NEXT(a_accept_enters, query.valid && query.ready, vld[0])
  `PPI_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld))

endmodule
